// File: hdl/ssdm_pkg.sv
package ssdm_pkg;

   localparam int NumDigits = 4;
   localparam int CharWidth = 8;
   localparam int SegWidth  = 7;

   localparam logic [SegWidth-1:0] SegA = 7'h01;
   localparam logic [SegWidth-1:0] SegB = 7'h02;
   localparam logic [SegWidth-1:0] SegC = 7'h04;
   localparam logic [SegWidth-1:0] SegD = 7'h08;
   localparam logic [SegWidth-1:0] SegE = 7'h10;
   localparam logic [SegWidth-1:0] SegF = 7'h20;
   localparam logic [SegWidth-1:0] SegG = 7'h40;
   localparam logic [SegWidth-1:0] SegAll = 7'h7F;

   localparam logic [0:0] ActionTick = 1'b0;
   localparam logic [0:0] ActionLoad = 1'b1;

   // sub-phase within one digit slot
   typedef enum logic [1:0] {
      StepBlank  = 2'd0,
      StepDrive  = 2'd1,
      StepEnable = 2'd2
   } step_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_m1;
      logic [CharWidth-1:0] char_m10;
      logic [CharWidth-1:0] char_h1;
      logic [CharWidth-1:0] char_h10;
      logic                 action;
   } req_word_type;

   typedef struct packed {
      logic [NumDigits-1:0] digit_enables;
      logic [SegWidth-1:0]  segment_lines;
   } rsp_word_type;

   function automatic logic [SegWidth-1:0] decode_char(input logic [CharWidth-1:0] c);
      logic [SegWidth-1:0] pat;
      unique case (c)
         8'h30:   pat = SegA | SegB | SegC | SegD | SegE | SegF;
         8'h31:   pat = SegB | SegC;
         8'h32:   pat = SegA | SegB | SegD | SegE | SegG;
         8'h33:   pat = SegA | SegB | SegC | SegD | SegG;
         8'h34:   pat = SegB | SegC | SegF | SegG;
         8'h35:   pat = SegA | SegC | SegD | SegF | SegG;
         8'h36:   pat = SegA | SegC | SegD | SegE | SegF | SegG;
         8'h37:   pat = SegA | SegB | SegC;
         8'h38:   pat = SegAll;
         8'h39:   pat = SegA | SegB | SegC | SegD | SegF | SegG;
         8'h6E:   pat = SegC | SegE | SegG;                 // 'n'
         8'h6F:   pat = SegC | SegD | SegE | SegG;          // 'o'
         8'h41:   pat = SegA | SegB | SegC | SegE | SegF | SegG; // 'A'
         8'h50:   pat = SegA | SegB | SegE | SegF | SegG;   // 'P'
         8'h20:   pat = '0;                                 // space
         default: pat = SegD;                               // unknown code
      endcase
      return pat;
   endfunction

endpackage

// File: hdl/ssdm_char_decode.sv
module ssdm_char_decode
   import ssdm_pkg::*;
(
   input  req_word_type        req_word,
   output logic [SegWidth-1:0] patterns [NumDigits]
);

   assign patterns[0] = decode_char(req_word.char_h10);
   assign patterns[1] = decode_char(req_word.char_h1);
   assign patterns[2] = decode_char(req_word.char_m10);
   assign patterns[3] = decode_char(req_word.char_m1);

endmodule

// File: hdl/ssdm_scan.sv
module ssdm_scan
   import ssdm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                action,
   input  logic [SegWidth-1:0] new_patterns [NumDigits],
   output rsp_word_type        rsp_next
);

   localparam int DigitIdxWidth = $clog2(NumDigits);

   logic [SegWidth-1:0]      patterns_ff [NumDigits];
   logic [SegWidth-1:0]      patterns_in [NumDigits];
   logic [DigitIdxWidth-1:0] digit_ff, digit_in;
   step_type                 step_ff, step_in;
   logic [SegWidth-1:0]      seg_ff, seg_in;
   logic [NumDigits-1:0]     en_ff, en_in;

   always_comb begin
      patterns_in = patterns_ff;
      digit_in    = digit_ff;
      step_in     = step_ff;
      seg_in      = seg_ff;
      en_in       = en_ff;
      if (fire) begin
         if (action == ActionLoad) begin
            patterns_in = new_patterns;
         end else begin
            unique case (step_ff)
               StepBlank: begin
                  en_in   = '0;
                  step_in = StepDrive;
               end
               StepDrive: begin
                  seg_in  = patterns_ff[digit_ff];
                  step_in = StepEnable;
               end
               StepEnable: begin
                  en_in    = en_ff | (NumDigits'(1) << digit_ff);
                  step_in  = StepBlank;
                  digit_in = digit_ff + DigitIdxWidth'(1);
               end
               default: begin
                  // out of cycle, clear the enables and restart at the drive step of the first digit
                  en_in    = '0;
                  step_in  = StepDrive;
                  digit_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumDigits; i++) begin
            patterns_ff[i] <= SegAll;
         end
         digit_ff <= '0;
         step_ff  <= StepBlank;
         seg_ff   <= '0;
         en_ff    <= '0;
      end else begin
         patterns_ff <= patterns_in;
         digit_ff    <= digit_in;
         step_ff     <= step_in;
         seg_ff      <= seg_in;
         en_ff       <= en_in;
      end
   end

   assign rsp_next.segment_lines = seg_in;
   assign rsp_next.digit_enables = en_in;

endmodule

// File: hdl/seven_segment_four_digit_mux.sv
// an accepted request word passes the input register and then the result register to become its response word
// throughput: one word per cycle while rsp_tready stays high; a stalled response holds the words behind it
// each tick advances the 12-phase scan (blank, drive, enable per digit) by one phase
// reset: synchronous, active high; pipeline empties, scan restarts at the
// blank phase of the first digit, patterns all lit, segments and enables off
module seven_segment_four_digit_mux
   import ssdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // char_h10 [7:0], char_h1 [15:8], char_m10 [23:16], char_m1 [31:24]
   input  logic [31:0] req_tdata,
   // action [0]: 0 tick, 1 load
   input  logic        req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // segment_lines [6:0], digit_enables [10:7], zero [15:11]
   output logic [15:0] rsp_tdata
);

   localparam int RspWidth = $bits(rsp_word_type);

   // input register stage
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;

   // result register stage
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic         advance;
   logic         req_fire;
   logic         core_fire;

   logic [SegWidth-1:0] new_patterns [NumDigits];
   rsp_word_type        rsp_next;

   // the result slot frees up when empty or being taken this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;
   assign core_fire  = in_valid_ff && advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (core_fire) begin
            out_word_in = rsp_next;
         end
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_word_in  = {req_tdata, req_tuser};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   // character decode for a load word
   ssdm_char_decode u_decode (
      .req_word (in_word_ff),
      .patterns (new_patterns)
   );

   // pattern store, scan phase and segment / enable levels
   ssdm_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .fire         (core_fire),
      .action       (in_word_ff.action),
      .new_patterns (new_patterns),
      .rsp_next     (rsp_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(16 - RspWidth)'(0), out_word_ff};

endmodule

// File: hdl/ssdm_checker.sv
module ssdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // pipeline is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the scan enables at most one digit at a time
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[10:7]))
      else $error("more than one digit enabled");

   // padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == 5'd0)
      else $error("response padding not zero");

   // a taken response frees space, so the input side is open next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready && !req_tvalid |=> req_tready)
      else $error("input blocked although output drains");

endmodule

bind seven_segment_four_digit_mux ssdm_checker u_ssdm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/seven_segment_four_digit_mux_tb.sv
module seven_segment_four_digit_mux_tb;
   import ssdm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one full scan covers blank, drive and enable for each of the four digits
   localparam int ScanLength = 12;
   localparam int TailCycles = 20;

   // segment glyphs for the numerals, index = digit value
   localparam logic [SegWidth-1:0] NumeralGlyph [10] = '{
      SegA | SegB | SegC | SegD | SegE | SegF,
      SegB | SegC,
      SegA | SegB | SegD | SegE | SegG,
      SegA | SegB | SegC | SegD | SegG,
      SegB | SegC | SegF | SegG,
      SegA | SegC | SegD | SegF | SegG,
      SegA | SegC | SegD | SegE | SegF | SegG,
      SegA | SegB | SegC,
      SegAll,
      SegA | SegB | SegC | SegD | SegF | SegG
   };

   // character codes that have their own glyph, used to bias random loads
   localparam logic [7:0] KnownChars [15] = '{
      "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "A", "P", "n", "o", " "
   };

   typedef struct packed {
      logic                 action;
      logic [31:0]          chars;     // h10 in the low byte, m1 in the high byte
      logic                 typed;     // expected readout written into the row
      logic [SegWidth-1:0]  segs;
      logic [NumDigits-1:0] digits;
   } scan_row_type;

   // directed sequence: reset readouts, every glyph, unknown codes, a full scan wrap
   localparam int NumRows = 25;
   localparam scan_row_type ScanRows [NumRows] = '{
      '{ActionTick, 32'h0000_0000, 1'b1, 7'h00, 4'h0},  // blank phase after reset
      '{ActionTick, 32'hFFFF_FFFF, 1'b1, 7'h7F, 4'h0},  // reset pattern driven
      '{ActionTick, 32'h0000_0000, 1'b1, 7'h7F, 4'h1},  // first digit enabled
      '{ActionLoad, 32'h3332_3130, 1'b1, 7'h7F, 4'h1},  // "0123", outputs unchanged
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},  // phase wraps to zero
      '{ActionLoad, 32'h3736_3534, 1'b0, 7'h00, 4'h0},  // "4567"
      '{ActionLoad, 32'h5041_3938, 1'b0, 7'h00, 4'h0},  // "89AP" over it
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionLoad, 32'hFF20_6F6E, 1'b0, 7'h00, 4'h0},  // 'n', 'o', space, 0xFF
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0},
      '{ActionLoad, 32'h807F_4200, 1'b0, 7'h00, 4'h0},  // 0x00, 'B', 0x7F, 0x80
      '{ActionTick, 32'h0000_0000, 1'b0, 7'h00, 4'h0},
      '{ActionTick, 32'hFFFF_FFFF, 1'b0, 7'h00, 4'h0}
   };

   localparam int NumRandom = 1400;
   localparam int PauseAt   = 700;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = ActionTick;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // typed expectation travels with the word on the input side
   logic         word_typed = 1'b0;
   rsp_word_type typed_readout = '0;

   // predicted display readouts, oldest first
   rsp_word_type due_readouts [$];
   int           errors = 0;

   // scan state of the predictor
   logic [3:0]           scan_phase;
   logic [SegWidth-1:0]  glyphs [NumDigits];
   logic [SegWidth-1:0]  lit_segments;
   logic [NumDigits-1:0] lit_digits;

   seven_segment_four_digit_mux dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // glyph for one character code; anything unknown lights segment d alone
   function automatic logic [SegWidth-1:0] glyph_of(input logic [7:0] code);
      logic [SegWidth-1:0] g;
      if (code >= "0" && code <= "9") begin
         g = NumeralGlyph[code - "0"];
      end else begin
         case (code)
            "A":     g = SegA | SegB | SegC | SegE | SegF | SegG;
            "P":     g = SegA | SegB | SegE | SegF | SegG;
            "n":     g = SegC | SegE | SegG;
            "o":     g = SegC | SegD | SegE | SegG;
            " ":     g = '0;
            default: g = SegD;
         endcase
      end
      return g;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(15, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   // load characters: mostly codes with a glyph, some arbitrary bytes
   function automatic logic [31:0] random_chars();
      logic [31:0] w;
      for (int d = 0; d < NumDigits; d++) begin
         if ($urandom_range(0, 3) != 0) begin
            w[8*d +: 8] = KnownChars[$urandom_range(0, 14)];
         end else begin
            w[8*d +: 8] = 8'($urandom_range(0, 255));
         end
      end
      return w;
   endfunction

   // predictor: on each accepted word step the scan or swap the patterns, queue the readout
   always @(posedge clock) begin
      int           p;
      int           slot;
      step_type     sub;
      rsp_word_type predicted;
      if (reset) begin
         scan_phase   = '0;
         lit_segments = '0;
         lit_digits   = '0;
         for (int d = 0; d < NumDigits; d++) begin
            glyphs[d] = SegAll;
         end
      end else if (req_tvalid && req_tready) begin
         if (req_tuser == ActionLoad) begin
            // a load only swaps patterns, the segment lines wait for a drive phase
            for (int d = 0; d < NumDigits; d++) begin
               glyphs[d] = glyph_of(req_tdata[8*d +: 8]);
            end
         end else begin
            p    = (scan_phase < ScanLength) ? int'(scan_phase) : 0;
            slot = p / 3;
            sub  = step_type'(2'(p % 3));
            case (sub)
               StepBlank: lit_digits = '0;
               StepDrive: lit_segments = glyphs[slot];
               default:   lit_digits = lit_digits | NumDigits'(1 << slot);
            endcase
            p = p + 1;
            if (p >= ScanLength) begin
               p = 0;
            end
            scan_phase = 4'(p);
         end
         predicted.segment_lines = lit_segments;
         predicted.digit_enables = lit_digits;
         due_readouts.push_back(word_typed ? typed_readout : predicted);
      end
   end

   // checker: every accepted response against the oldest readout
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata[10:0]);
         if (due_readouts.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = due_readouts.pop_front();
            if (got.segment_lines !== want.segment_lines) begin
               errors++;
               $display("%0t: segment_lines expected %h actual %h",
                        $time, want.segment_lines, got.segment_lines);
            end
            if (got.digit_enables !== want.digit_enables) begin
               errors++;
               $display("%0t: digit_enables expected %h actual %h",
                        $time, want.digit_enables, got.digit_enables);
            end
            if (rsp_tdata[15:11] !== 5'h00) begin
               errors++;
               $display("%0t: pad bits expected 00 actual %h", $time, rsp_tdata[15:11]);
            end
         end
      end
   end

   // response side back-pressure: calm stretches and random stalls
   initial begin
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else if ($urandom_range(0, 99) < 4) begin
               calm_left = $urandom_range(50, 200);
            end else if ($urandom_range(0, 99) < 25) begin
               stall_left = gap_length();
            end
         end
      end
   end

   // hold the input valid low while idling
   task automatic idle_cycles(input int n);
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // present one word and wait for the handshake
   task automatic send_word(input logic act, input logic [31:0] chars,
                            input logic typed, input rsp_word_type readout);
      @(negedge clock);
      req_tvalid    <= 1'b1;
      req_tuser     <= act;
      req_tdata     <= chars;
      word_typed    <= typed;
      typed_readout <= readout;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   // sender side gaps between words, skipped during calm stretches
   task automatic maybe_gap(inout int calm_items);
      if (calm_items > 0) begin
         calm_items--;
      end else if ($urandom_range(0, 99) < 3) begin
         calm_items = $urandom_range(30, 120);
      end else if ($urandom_range(0, 99) < 30) begin
         idle_cycles(gap_length());
      end
   endtask

   initial begin
      int           calm_items;
      rsp_word_type readout;
      logic         act;
      calm_items = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (int r = 0; r < NumRows; r++) begin
         readout.segment_lines = ScanRows[r].segs;
         readout.digit_enables = ScanRows[r].digits;
         send_word(ScanRows[r].action, ScanRows[r].chars, ScanRows[r].typed, readout);
         maybe_gap(calm_items);
      end

      // random part: mostly ticks that sweep the scan, with a load now and then
      readout = '0;
      for (int i = 0; i < NumRandom; i++) begin
         if (i == PauseAt) begin
            // drain everything before carrying on
            idle_cycles(1);
            while (due_readouts.size() != 0) @(posedge clock);
         end
         act = ($urandom_range(0, 7) == 0) ? ActionLoad : ActionTick;
         send_word(act, (act == ActionLoad) ? random_chars() : $urandom(), 1'b0, readout);
         maybe_gap(calm_items);
      end
      idle_cycles(1);

      while (due_readouts.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (errors == 0 && due_readouts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
